// ===== hw/rtl/rhc_pkg.sv =====
`default_nettype none

package rhc_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int FRACTION_BITS = 16;

  // divider word: holds 6*CMAX, the widest divisor (hue)
  localparam int DEN_BITS = CHANNEL_BITS + 3;

  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES =
      (FRACTION_BITS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

  localparam logic [CHANNEL_BITS-1:0]  CMAX  = '1;
  localparam logic [CHANNEL_BITS:0]    CMAX2 = {CMAX, 1'b0};
  localparam logic [FRACTION_BITS-1:0] FMAX  = '1;

  localparam int NUM_LANES  = 3;
  localparam int LANE_HUE   = 0;
  localparam int LANE_SAT   = 1;
  localparam int LANE_LIGHT = 2;

  typedef logic [CHANNEL_BITS-1:0]  chan_t;
  typedef logic [FRACTION_BITS-1:0] frac_t;
  typedef logic [DEN_BITS-1:0]      den_t;

  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_sel_e;

  // one fraction divider lane: remainder, divisor, quotient so far
  typedef struct packed {
    den_t  rem;
    den_t  den;
    frac_t quo;
  } lane_t;

  typedef struct packed {
    logic grey;
    logic sat_full;
    logic light_full;
  } flag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rhc_if.sv =====
`default_nettype none

interface rhc_in_if
  import rhc_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;
  chan_t alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

interface rhc_out_if
  import rhc_pkg::*;
();
  logic  valid;
  logic  ready;
  frac_t hue;
  frac_t saturation;
  frac_t lightness;
  chan_t alpha_out;

  modport source (output valid, output hue, output saturation, output lightness,
                  output alpha_out, input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  input alpha_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rgb_to_hsl_converter.sv =====
// port     dir  word
// pix_i    in   red, green, blue, alpha (8 bit each)
// hsl_o    out  hue, saturation, lightness (Q0.16), alpha_out (8 bit)
//
// One pixel per cycle sustained while hsl_o.ready is high; stages: A, operands, DIV_STAGES divider, output.
// Latency is set by the three fraction dividers, 4 quotient bits per stage each.
// Reset clears the valid bits only; the datapath needs none.
// All stages hold together while the output word waits; pix_i.ready is low then.
`default_nettype none

module rgb_to_hsl_converter
  import rhc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  rhc_in_if.sink     pix_i,
  rhc_out_if.source  hsl_o
);

  logic en;

  // stage A: max / min
  logic     vld_a_q;
  chan_t    r_a_q, g_a_q, b_a_q, alpha_a_q, mx_a_q, mn_a_q;
  max_sel_e sel_a_q;
  chan_t    mx_d, mn_d;
  max_sel_e sel_d;

  // stage 0 = operands, stages 1..DIV_STAGES = divider
  logic  vld_q   [DIV_STAGES+1];
  lane_t lane_q  [DIV_STAGES+1][NUM_LANES];
  flag_t flag_q  [DIV_STAGES+1];
  chan_t alpha_q [DIV_STAGES+1];
  lane_t lane_d  [DIV_STAGES][NUM_LANES];

  lane_t lane0_d [NUM_LANES];
  flag_t flag0_d;

  // output register
  logic  vld_o_q;
  frac_t hue_q, sat_q, light_q;
  chan_t alpha_o_q;

  assign en          = !vld_o_q || hsl_o.ready;
  assign pix_i.ready = en;

  always_comb begin
    mx_d  = pix_i.red;
    sel_d = MAX_RED;
    if (pix_i.red < pix_i.green) begin
      mx_d  = pix_i.green;
      sel_d = MAX_GREEN;
    end
    if (pix_i.blue > mx_d) begin
      mx_d  = pix_i.blue;
      sel_d = MAX_BLUE;
    end
    mn_d = pix_i.red;
    if (pix_i.green < mn_d) begin
      mn_d = pix_i.green;
    end
    if (pix_i.blue < mn_d) begin
      mn_d = pix_i.blue;
    end
  end

  // operands: hue numerator n over 6d, saturation d over den, lightness sum over 2*CMAX
  always_comb begin
    logic [CHANNEL_BITS-1:0] d;
    logic [CHANNEL_BITS:0]   sum;
    logic [CHANNEL_BITS:0]   sat_den;
    den_t d_x, d2, d4, d6, r_x, g_x, b_x, n;
    d       = mx_a_q - mn_a_q;
    sum     = {1'b0, mx_a_q} + {1'b0, mn_a_q};
    d_x     = DEN_BITS'(d);
    d2      = d_x << 1;
    d4      = d_x << 2;
    d6      = d4 + d2;
    r_x     = DEN_BITS'(r_a_q);
    g_x     = DEN_BITS'(g_a_q);
    b_x     = DEN_BITS'(b_a_q);
    unique case (sel_a_q)
      MAX_RED: begin
        n = (g_x >= b_x) ? (g_x - b_x) : (d6 - (b_x - g_x));
      end
      MAX_GREEN: begin
        n = (b_x >= r_x) ? (d2 + (b_x - r_x)) : (d2 - (r_x - b_x));
      end
      MAX_BLUE: begin
        n = (r_x >= g_x) ? (d4 + (r_x - g_x)) : (d4 - (g_x - r_x));
      end
      default: begin
        n = '0;
      end
    endcase
    if (n >= d6) begin
      n = n - d6;
    end
    sat_den = (sum > {1'b0, CMAX}) ? (CMAX2 - sum) : sum;

    flag0_d.grey       = (d == '0);
    flag0_d.sat_full   = ({1'b0, d} == sat_den);
    flag0_d.light_full = (sum == CMAX2);

    lane0_d[LANE_HUE].rem   = n;
    lane0_d[LANE_HUE].den   = d6;
    lane0_d[LANE_HUE].quo   = '0;
    lane0_d[LANE_SAT].rem   = d_x;
    lane0_d[LANE_SAT].den   = DEN_BITS'(sat_den);
    lane0_d[LANE_SAT].quo   = '0;
    lane0_d[LANE_LIGHT].rem = DEN_BITS'(sum);
    lane0_d[LANE_LIGHT].den = DEN_BITS'(CMAX2);
    lane0_d[LANE_LIGHT].quo = '0;
  end

  // restoring fraction divide: numerator < divisor, one quotient bit per step
  always_comb begin
    lane_t              t;
    logic [DEN_BITS:0]  rem2;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        t = lane_q[s][l];
        for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
          if (s * DIV_BITS_PER_STAGE + j < FRACTION_BITS) begin
            rem2 = {t.rem, 1'b0};
            if (rem2 >= {1'b0, t.den}) begin
              t.rem = DEN_BITS'(rem2 - {1'b0, t.den});
              t.quo = {t.quo[FRACTION_BITS-2:0], 1'b1};
            end else begin
              t.rem = rem2[DEN_BITS-1:0];
              t.quo = {t.quo[FRACTION_BITS-2:0], 1'b0};
            end
          end
        end
        lane_d[s][l] = t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      for (int s = 0; s <= DIV_STAGES; s++) begin
        vld_q[s] <= 1'b0;
      end
      vld_o_q <= 1'b0;
    end else if (en) begin
      vld_a_q  <= pix_i.valid;
      vld_q[0] <= vld_a_q;
      for (int s = 0; s < DIV_STAGES; s++) begin
        vld_q[s+1] <= vld_q[s];
      end
      vld_o_q <= vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_a_q     <= pix_i.red;
      g_a_q     <= pix_i.green;
      b_a_q     <= pix_i.blue;
      alpha_a_q <= pix_i.alpha;
      mx_a_q    <= mx_d;
      mn_a_q    <= mn_d;
      sel_a_q   <= sel_d;

      lane_q[0]  <= lane0_d;
      flag_q[0]  <= flag0_d;
      alpha_q[0] <= alpha_a_q;
      for (int s = 0; s < DIV_STAGES; s++) begin
        lane_q[s+1]  <= lane_d[s];
        flag_q[s+1]  <= flag_q[s];
        alpha_q[s+1] <= alpha_q[s];
      end

      hue_q     <= flag_q[DIV_STAGES].grey ? '0 : lane_q[DIV_STAGES][LANE_HUE].quo;
      sat_q     <= flag_q[DIV_STAGES].grey     ? '0   :
                   flag_q[DIV_STAGES].sat_full ? FMAX :
                   lane_q[DIV_STAGES][LANE_SAT].quo;
      light_q   <= flag_q[DIV_STAGES].light_full ? FMAX :
                   lane_q[DIV_STAGES][LANE_LIGHT].quo;
      alpha_o_q <= alpha_q[DIV_STAGES];
    end
  end

  assign hsl_o.valid      = vld_o_q;
  assign hsl_o.hue        = hue_q;
  assign hsl_o.saturation = sat_q;
  assign hsl_o.lightness  = light_q;
  assign hsl_o.alpha_out  = alpha_o_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rhc_checker.sv =====
`default_nettype none

module rhc_props
  import rhc_pkg::*;
(
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire frac_t hue_i,
  input wire frac_t saturation_i,
  input wire frac_t lightness_i,
  input wire chan_t alpha_out_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(hue_i) && $stable(saturation_i) &&
                                    $stable(lightness_i) && $stable(alpha_out_i))
    else $error("output word changed while stalled");

  // an empty output register never backpressures the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // nonzero hue needs max != min, so saturation is nonzero
  a_hue_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (hue_i != '0) |-> (saturation_i != '0))
    else $error("hue without saturation");

  // full lightness only for white, which is grey
  a_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (lightness_i == FMAX) |-> (saturation_i == '0) && (hue_i == '0))
    else $error("white pixel with hue or saturation");

endmodule

bind rgb_to_hsl_converter rhc_props u_rhc_props (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (pix_i.ready),
  .out_valid_i  (hsl_o.valid),
  .out_ready_i  (hsl_o.ready),
  .hue_i        (hsl_o.hue),
  .saturation_i (hsl_o.saturation),
  .lightness_i  (hsl_o.lightness),
  .alpha_out_i  (hsl_o.alpha_out)
);

`default_nettype wire
